FILE: rtl/hcd_pkg.sv
`default_nettype none

package hcd_pkg;

    // Width of a chunk size in bits
    localparam int SIZE_BITS = 32;

    // Line delimiters
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // One classified input byte, as passed from the front to the back
    typedef struct packed {
        logic [7:0] data;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
    } hcd_tok_t;

endpackage

`default_nettype wire

FILE: rtl/hcd_front.sv
`default_nettype none

module hcd_front
    import hcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // byte stream in
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    // classified tokens toward the back
    output logic            tok_valid,
    output hcd_tok_t        tok,
    input  wire logic       tok_pop
);

    localparam int QDEPTH = 2;

    hcd_tok_t   q_reg [QDEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    hcd_tok_t   cls;
    logic       push;
    logic       pop;

    // Classify the incoming byte: hex digit value, CR, LF
    always_comb
    begin
        cls.data    = in_byte;
        cls.is_cr   = (in_byte == CH_CR);
        cls.is_lf   = (in_byte == CH_LF);
        cls.is_hex  = 1'b0;
        cls.hex_val = 4'd0;
        if (in_byte inside {[8'h30:8'h39]})
        begin
            cls.is_hex  = 1'b1;
            cls.hex_val = in_byte[3:0];
        end
        else if (in_byte inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            // 'A'..'F' and 'a'..'f': low nibble 1..6 maps to 10..15
            cls.is_hex  = 1'b1;
            cls.hex_val = in_byte[3:0] + 4'd9;
        end
    end

    assign in_ready  = (count_reg != 2'(QDEPTH));
    assign push      = in_valid && in_ready;
    assign tok_valid = (count_reg != 2'd0);
    assign pop       = tok_pop && tok_valid;
    assign tok       = q_reg[rd_ptr_reg];

    // Occupancy update
    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    // Queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule

`default_nettype wire

FILE: rtl/hcd_back.sv
`default_nettype none

module hcd_back
    import hcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // classified tokens from the front
    input  wire logic       tok_valid,
    input  wire hcd_tok_t   tok,
    output logic            tok_pop,
    // result channel
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      payload_byte,
    output logic            payload_valid,
    output logic            finished,
    output logic            format_error
);

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_SIZE_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_DONE,
        PH_ERROR
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   remaining_reg, remaining_next;
    logic [3:0]             digit_reg, digit_next;
    logic                   out_valid_reg;
    logic [7:0]             pbyte_reg, pbyte_next;
    logic                   pvalid_reg, pvalid_next;
    logic                   advance;

    // Take a token whenever the output register is free or being emptied
    assign advance = tok_valid && (!out_valid_reg || out_ready);
    assign tok_pop = advance;

    // Phase transitions for one token
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        digit_next     = digit_reg;
        pbyte_next     = 8'd0;
        pvalid_next    = 1'b0;
        case (phase_reg)
            PH_SIZE:
            begin
                if (tok.is_hex)
                begin
                    // top nibble busy: one more digit would overflow
                    if (remaining_reg[SIZE_BITS-1 -: 4] != 4'd0)
                        phase_next = PH_ERROR;
                    else
                    begin
                        remaining_next = {remaining_reg[SIZE_BITS-5:0], tok.hex_val};
                        if (digit_reg != 4'hF)
                            digit_next = digit_reg + 4'd1;
                    end
                end
                else if (tok.is_cr && digit_reg != 4'd0)
                    phase_next = PH_SIZE_LF;
                else
                    phase_next = PH_ERROR;
            end
            PH_SIZE_LF:
            begin
                if (!tok.is_lf)
                    phase_next = PH_ERROR;
                else if (remaining_reg == '0)
                    phase_next = PH_DONE;
                else
                    phase_next = PH_DATA;
                digit_next = 4'd0;
            end
            PH_DATA:
            begin
                pbyte_next     = tok.data;
                pvalid_next    = 1'b1;
                remaining_next = remaining_reg - SIZE_BITS'(1);
                if (remaining_reg == SIZE_BITS'(1))
                    phase_next = PH_DATA_CR;
            end
            PH_DATA_CR:
                phase_next = tok.is_cr ? PH_DATA_LF : PH_ERROR;
            PH_DATA_LF:
            begin
                if (tok.is_lf)
                begin
                    phase_next     = PH_SIZE;
                    remaining_next = '0;
                    digit_next     = 4'd0;
                end
                else
                    phase_next = PH_ERROR;
            end
            PH_DONE:
                phase_next = PH_DONE;
            default:
                phase_next = PH_ERROR;
        endcase
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE;
            remaining_reg <= '0;
            digit_reg     <= 4'd0;
            out_valid_reg <= 1'b0;
            pbyte_reg     <= 8'd0;
            pvalid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg     <= phase_next;
                remaining_reg <= remaining_next;
                digit_reg     <= digit_next;
                pbyte_reg     <= pbyte_next;
                pvalid_reg    <= pvalid_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Flags follow the phase that the last transaction left behind
    assign out_valid     = out_valid_reg;
    assign payload_byte  = pbyte_reg;
    assign payload_valid = pvalid_reg;
    assign finished      = (phase_reg == PH_DONE);
    assign format_error  = (phase_reg == PH_ERROR);

endmodule

`default_nettype wire

FILE: rtl/http_chunked_decoder.sv
// HTTP/1.1 chunked transfer decoder.
// Input channel (in_valid/in_ready/in_byte) takes one body byte per
// transaction. Output channel (out_valid/out_ready) returns exactly one
// result per input byte: payload_byte/payload_valid when the byte was chunk
// data (payload_byte is 0 otherwise), plus the sticky finished and
// format_error flags as they stand after that byte.
// A front stage classifies each byte and parks it in a two-entry queue; a
// back stage runs the size/data/CRLF parser and holds the result register.
// Each accepted byte is written into the queue, then the back stage moves it
// into the result register. Throughput: one byte per cycle while the result
// register is free or out_ready empties it.
// When out_ready is low the result register holds; the queue keeps taking
// bytes until both entries are full, then in_ready drops.
// Reset clears the queue and puts the parser at the first size digit. After
// finished or format_error, bytes still produce results with payload_valid
// low and the flags unchanged until reset.
`default_nettype none

module http_chunked_decoder
    import hcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      payload_byte,
    output logic            payload_valid,
    output logic            finished,
    output logic            format_error
);

    logic     tok_valid;
    logic     tok_pop;
    hcd_tok_t tok;

    hcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop)
    );

    hcd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .tok_valid     (tok_valid),
        .tok           (tok),
        .tok_pop       (tok_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .finished      (finished),
        .format_error  (format_error)
    );

endmodule

`default_nettype wire
